### hw/rtl/hme_pkg.sv
// ----------------------------------------------------------------------------
// hme_pkg
// Shared widths, types, opcodes and count helpers for the histogram mode
// engine.
// ----------------------------------------------------------------------------
package hme_pkg;

  localparam int MAX_BINS   = 256;
  localparam int ADDR_W     = $clog2(MAX_BINS);
  localparam int NB_W       = ADDR_W + 1;
  localparam int COUNT_BITS = 32;

  typedef logic [2:0]            opcode_t;
  typedef logic signed [15:0]    sample_t;
  typedef logic [ADDR_W-1:0]     bin_t;
  typedef logic [NB_W-1:0]       nbins_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam opcode_t OP_CLEAR = 3'd0;
  localparam opcode_t OP_ADD   = 3'd1;
  localparam opcode_t OP_CHECK = 3'd2;
  localparam opcode_t OP_FIX   = 3'd3;
  localparam opcode_t OP_MODE  = 3'd4;
  localparam opcode_t OP_READ  = 3'd5;

  localparam nbins_t NUM_BINS_RESET = 9'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RD_B,
    ST_RD_H,
    ST_EVAL,
    ST_WR_H,
    ST_RD_S,
    ST_CAP_S,
    ST_SCAN,
    ST_DONE
  } state_t;

  function automatic count_t sat_add(input count_t a, input logic [1:0] amt);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, a} + {{(COUNT_BITS - 1){1'b0}}, amt};
    return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  endfunction

  function automatic count_t floor_dec(input count_t a);
    return (a == '0) ? a : a - count_t'(1);
  endfunction

endpackage

### hw/rtl/hme_if.sv
// ----------------------------------------------------------------------------
// hme_if
// Valid/ready channels for the histogram mode engine: the command channel
// and the result channel.
// ----------------------------------------------------------------------------
interface hme_in_if;
  import hme_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  sample_t sample;
  bin_t    bin_select;

  modport source (output valid, output opcode, output sample, output bin_select,
                  input ready);
  modport sink   (input valid, input opcode, input sample, input bin_select,
                  output ready);
endinterface

interface hme_out_if;
  import hme_pkg::*;

  logic   valid;
  logic   ready;
  bin_t   bin_index;
  count_t bin_count;
  count_t half_count;
  logic   two_lambda;
  logic   found;

  modport source (output valid, output bin_index, output bin_count, output half_count,
                  output two_lambda, output found, input ready);
  modport sink   (input valid, input bin_index, input bin_count, input half_count,
                  input two_lambda, input found, output ready);
endinterface

### hw/rtl/histogram_mode_engine_core.sv
// ----------------------------------------------------------------------------
// histogram_mode_engine_core
// Fixed-range histogram of signed 16-bit samples with mode search, built
// around one count memory with separate read and write ports.
// ----------------------------------------------------------------------------
// One command is processed at a time, and the next command is taken while a
// finished result still waits in the output register. Add, check and fix
// run through the states MUL, DIV, RD_B, RD_H and EVAL, and fix adds WR_H:
// the offset sample is multiplied by the bin count, and the product is
// divided by the fixed span with a shift and one correction step, since the
// span lies just below a power of two; then the count memory is read and
// written through its read and write ports. Read count passes RD_S and CAP_S,
// and clear goes straight to DONE, since a bank of per-bin valid bits clears
// all counts at once. Report mode walks the bins in use through the memory
// read port. Every command waits in DONE while the previous result still
// waits in the output register.
module histogram_mode_engine_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  hme_pkg::nbins_t   cfg_wdata,
  hme_in_if.sink            in_ch,
  hme_out_if.source         out_ch
);
  import hme_pkg::*;

  localparam logic [25:0] RND_B  = 26'd32767;
  localparam logic [25:0] RND_H  = 26'd65534;

  count_t mem [MAX_BINS];

  state_t              state_r, state_nxt;
  nbins_t              num_bins_r;
  logic [MAX_BINS-1:0] valid_r, valid_nxt;
  count_t              rd_data_r;
  logic                rd_vld_r;

  opcode_t     op_r, op_nxt;
  sample_t     sample_r, sample_nxt;
  bin_t        sel_r, sel_nxt;
  nbins_t      n_r, n_nxt;
  logic [25:0] rem_b_r, rem_b_nxt, rem_h_r, rem_h_nxt;
  nbins_t      q_b_r, q_b_nxt, q_h_r, q_h_nxt;
  bin_t        b_r, b_nxt, h_r, h_nxt;
  count_t      cb_r, cb_nxt, nh_r, nh_nxt;
  nbins_t      scan_r, scan_nxt;
  logic        pend_r, pend_nxt;
  bin_t        pidx_r, pidx_nxt;
  count_t      best_r, best_nxt;
  bin_t        where_r, where_nxt;

  bin_t   res_index_r, res_index_nxt;
  count_t res_count_r, res_count_nxt;
  count_t res_half_r, res_half_nxt;
  logic   res_tl_r, res_tl_nxt;
  logic   res_found_r, res_found_nxt;

  logic   out_valid_r, out_valid_nxt;
  bin_t   out_index_r, out_index_nxt;
  count_t out_count_r, out_count_nxt;
  count_t out_half_r, out_half_nxt;
  logic   out_tl_r, out_tl_nxt;
  logic   out_found_r, out_found_nxt;

  bin_t   rd_addr;
  logic   wr_en;
  bin_t   wr_addr;
  count_t wr_data;
  count_t rdata;

  nbins_t      n_used;
  logic [15:0] num_b;
  logic [16:0] num_h;
  logic        corr_b, corr_h;
  nbins_t      n_m1, qb_cl, qh_cl;
  count_t      new_b, new_h;
  logic        same_bin;

  assign rdata = rd_vld_r ? rd_data_r : '0;

  assign n_used = (num_bins_r == '0) ? nbins_t'(1) :
                  (num_bins_r > nbins_t'(MAX_BINS)) ? nbins_t'(MAX_BINS) : num_bins_r;

  assign num_b = (sample_r == 16'sh8000) ? 16'd0 :
                 16'(17'(signed'(sample_r)) + 17'sd32767);
  assign num_h = 17'(18'(signed'(sample_r)) + 18'sd65534);

  assign corr_b = ({7'd0, rem_b_r[24:16], 1'b0} + {1'b0, rem_b_r[15:0]}) >= 17'd65534;
  assign corr_h = ({8'd0, rem_h_r[25:17], 2'b00} + {2'b00, rem_h_r[16:0]}) >= 19'd131068;

  assign n_m1    = n_r - nbins_t'(1);
  assign qb_cl   = (q_b_r > n_m1) ? n_m1 : q_b_r;
  assign qh_cl   = (q_h_r > n_m1) ? n_m1 : q_h_r;

  assign same_bin = (b_r == h_r);
  assign new_b    = floor_dec(cb_r);
  assign new_h    = sat_add(same_bin ? new_b : rdata, 2'd2);

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    op_nxt        = op_r;
    sample_nxt    = sample_r;
    sel_nxt       = sel_r;
    n_nxt         = n_r;
    rem_b_nxt     = rem_b_r;
    rem_h_nxt     = rem_h_r;
    q_b_nxt       = q_b_r;
    q_h_nxt       = q_h_r;
    b_nxt         = b_r;
    h_nxt         = h_r;
    cb_nxt        = cb_r;
    nh_nxt        = nh_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    best_nxt      = best_r;
    where_nxt     = where_r;
    res_index_nxt = res_index_r;
    res_count_nxt = res_count_r;
    res_half_nxt  = res_half_r;
    res_tl_nxt    = res_tl_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_index_nxt = out_index_r;
    out_count_nxt = out_count_r;
    out_half_nxt  = out_half_r;
    out_tl_nxt    = out_tl_r;
    out_found_nxt = out_found_r;
    rd_addr       = b_r;
    wr_en         = 1'b0;
    wr_addr       = b_r;
    wr_data       = new_b;
    in_ch.ready   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt        = in_ch.opcode;
          sample_nxt    = in_ch.sample;
          sel_nxt       = in_ch.bin_select;
          n_nxt         = n_used;
          res_index_nxt = '0;
          res_count_nxt = '0;
          res_half_nxt  = '0;
          res_tl_nxt    = 1'b0;
          res_found_nxt = 1'b0;
          case (in_ch.opcode)
            OP_CLEAR: begin
              valid_nxt = '0;
              state_nxt = ST_DONE;
            end
            OP_ADD, OP_CHECK, OP_FIX: state_nxt = ST_MUL;
            OP_MODE: begin
              scan_nxt  = '0;
              pend_nxt  = 1'b0;
              best_nxt  = '0;
              where_nxt = '0;
              state_nxt = ST_SCAN;
            end
            OP_READ: state_nxt = ST_RD_S;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        rem_b_nxt = 26'(num_b) * 26'(n_r) + RND_B;
        rem_h_nxt = 26'(num_h) * 26'(n_r) + RND_H;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        q_b_nxt   = rem_b_r[24:16] + nbins_t'(corr_b);
        q_h_nxt   = rem_h_r[25:17] + nbins_t'(corr_h);
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        b_nxt     = qb_cl[ADDR_W-1:0];
        h_nxt     = qh_cl[ADDR_W-1:0];
        rd_addr   = qb_cl[ADDR_W-1:0];
        state_nxt = ST_RD_H;
      end
      ST_RD_H: begin
        rd_addr   = h_r;
        cb_nxt    = rdata;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        res_index_nxt = b_r;
        state_nxt     = ST_DONE;
        case (op_r)
          OP_ADD: begin
            wr_en         = 1'b1;
            wr_data       = sat_add(cb_r, 2'd1);
            res_count_nxt = sat_add(cb_r, 2'd1);
          end
          OP_CHECK: begin
            res_count_nxt = cb_r;
            res_half_nxt  = rdata;
            res_tl_nxt    = rdata > cb_r;
          end
          OP_FIX: begin
            wr_en         = 1'b1;
            nh_nxt        = new_h;
            res_count_nxt = same_bin ? new_h : new_b;
            res_half_nxt  = new_h;
            res_tl_nxt    = rdata > cb_r;
            state_nxt     = ST_WR_H;
          end
          default: ;
        endcase
      end
      ST_WR_H: begin
        wr_en     = 1'b1;
        wr_addr   = h_r;
        wr_data   = nh_r;
        state_nxt = ST_DONE;
      end
      ST_RD_S: begin
        rd_addr   = sel_r;
        state_nxt = ST_CAP_S;
      end
      ST_CAP_S: begin
        res_index_nxt = sel_r;
        res_count_nxt = rdata;
        state_nxt     = ST_DONE;
      end
      ST_SCAN: begin
        rd_addr = scan_r[ADDR_W-1:0];
        if (pend_r && (rdata > best_r)) begin
          best_nxt  = rdata;
          where_nxt = pidx_r;
        end
        if (scan_r < n_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r[ADDR_W-1:0];
          scan_nxt = scan_r + nbins_t'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            res_index_nxt = where_r;
            res_count_nxt = best_r;
            res_found_nxt = (best_r != '0);
            state_nxt     = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_index_r;
          out_count_nxt = res_count_r;
          out_half_nxt  = res_half_r;
          out_tl_nxt    = res_tl_r;
          out_found_nxt = res_found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_bins_r  <= NUM_BINS_RESET;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        num_bins_r <= cfg_wdata;
      end
      valid_r     <= valid_nxt;
      rd_vld_r    <= valid_r[rd_addr];
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    sample_r    <= sample_nxt;
    sel_r       <= sel_nxt;
    n_r         <= n_nxt;
    rem_b_r     <= rem_b_nxt;
    rem_h_r     <= rem_h_nxt;
    q_b_r       <= q_b_nxt;
    q_h_r       <= q_h_nxt;
    b_r         <= b_nxt;
    h_r         <= h_nxt;
    cb_r        <= cb_nxt;
    nh_r        <= nh_nxt;
    scan_r      <= scan_nxt;
    pidx_r      <= pidx_nxt;
    best_r      <= best_nxt;
    where_r     <= where_nxt;
    res_index_r <= res_index_nxt;
    res_count_r <= res_count_nxt;
    res_half_r  <= res_half_nxt;
    res_tl_r    <= res_tl_nxt;
    res_found_r <= res_found_nxt;
    out_index_r <= out_index_nxt;
    out_count_r <= out_count_nxt;
    out_half_r  <= out_half_nxt;
    out_tl_r    <= out_tl_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bin_index  = out_index_r;
  assign out_ch.bin_count  = out_count_r;
  assign out_ch.half_count = out_half_r;
  assign out_ch.two_lambda = out_tl_r;
  assign out_ch.found      = out_found_r;

endmodule
